/* hw/rtl/srl_pkg.sv */
// Shared types and codes for the sequential record list.
`default_nettype none

package srl_pkg;

	localparam int unsigned POS_W   = 6;
	localparam int unsigned COUNT_W = 6;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_FIND   = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_READ   = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  age;
		logic [9:0]  height;
		logic [31:0] weight;
	} rec_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [POS_W-1:0] position;
		logic [7:0]       in_age;
		logic [9:0]       in_height;
		logic [31:0]      in_weight;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [7:0]         out_age;
		logic [9:0]         out_height;
		logic [31:0]        out_weight;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_IDX,
		RD_IDX_PREV
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_TAIL,
		WR_POS,
		WR_IDX
	} wr_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FIND_RD,
		S_FIND_CMP,
		S_READ_WAIT,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    ld_item;
		logic    mem_wr;
		wr_sel_t wr_sel;
		logic    mem_rd;
		rd_sel_t rd_sel;
		logic    idx_load_fill;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_dec;
		logic    fill_inc;
		logic    fill_dec;
		logic    fill_clr;
		logic    st_set;
		status_t st_code;
		logic    found_set;
		logic    rdout_cap;
		logic    out_load;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] cmd;
		logic       full;
		logic       empty;
		logic       pos_gt_fill;
		logic       pos_ge_fill;
		logic       idx_gt_pos;
		logic       idx_lt_fill;
		logic       match;
		logic       out_free;
	} stat_t;

endpackage

`default_nettype wire

/* hw/rtl/srl_req_if.sv */
// Command channel interface for the sequential record list.
`default_nettype none

interface srl_req_if;
	logic          valid;
	logic          ready;
	srl_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/srl_rsp_if.sv */
// Result channel interface for the sequential record list.
`default_nettype none

interface srl_rsp_if;
	logic          valid;
	logic          ready;
	srl_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sequential_record_list.sv */
// Sequential record list: a bounded ordered list of age/height/weight records in
// a single-port memory with registered read. One command is taken at a time and
// gives one result. Insert moves each entry from the position up by one place and
// find examines entries from the first until one matches; each moved or compared
// entry needs one memory read and then one write or compare.
// The next command is accepted once the previous result is in the output register,
// even while that result waits to be taken. The memory has no reset; reset clears
// only the fill count, the result valid flag and the controller state.
`default_nettype none

module sequential_record_list #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srl_req_if.sink   req,
	srl_rsp_if.source rsp
);

	srl_pkg::ctrl_t ctrl;
	srl_pkg::stat_t stat;

	srl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	srl_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.ctrl      (ctrl),
		.stat      (stat),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

	// one command in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command accepted while another is in progress");

	// a match is only reported with ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.found |-> rsp.data.status == srl_pkg::ST_OK)
		else $error("found flag with non-ok status");

	// refused commands carry no record
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status != srl_pkg::ST_OK |->
		rsp.data.out_age == '0 && rsp.data.out_height == '0 && rsp.data.out_weight == '0)
		else $error("record fields set on refused command");

	// loading a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !rsp.valid || rsp.ready)
		else $error("result register overwritten");

endmodule

`default_nettype wire

/* hw/rtl/srl_ctrl.sv */
// Controller state machine for the sequential record list.
`default_nettype none

module srl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire srl_pkg::stat_t  stat,
	output srl_pkg::ctrl_t       ctrl
);

	srl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == srl_pkg::S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srl_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = srl_pkg::S_EXEC;
				end
			end
			srl_pkg::S_EXEC: begin
				case (stat.cmd)
					srl_pkg::CMD_INSERT: begin
						if (!stat.pos_gt_fill && !stat.full) begin
							state_d = srl_pkg::S_SHIFT_RD;
						end else begin
							state_d = srl_pkg::S_FINISH;
						end
					end
					srl_pkg::CMD_FIND: begin
						state_d = srl_pkg::S_FIND_RD;
					end
					srl_pkg::CMD_READ: begin
						if (!stat.empty && !stat.pos_ge_fill) begin
							state_d = srl_pkg::S_READ_WAIT;
						end else begin
							state_d = srl_pkg::S_FINISH;
						end
					end
					default: begin
						state_d = srl_pkg::S_FINISH;
					end
				endcase
			end
			srl_pkg::S_SHIFT_RD: begin
				if (stat.idx_gt_pos) begin
					state_d = srl_pkg::S_SHIFT_WR;
				end else begin
					state_d = srl_pkg::S_FINISH;
				end
			end
			srl_pkg::S_SHIFT_WR: begin
				state_d = srl_pkg::S_SHIFT_RD;
			end
			srl_pkg::S_FIND_RD: begin
				if (stat.idx_lt_fill) begin
					state_d = srl_pkg::S_FIND_CMP;
				end else begin
					state_d = srl_pkg::S_FINISH;
				end
			end
			srl_pkg::S_FIND_CMP: begin
				if (stat.match) begin
					state_d = srl_pkg::S_FINISH;
				end else begin
					state_d = srl_pkg::S_FIND_RD;
				end
			end
			srl_pkg::S_READ_WAIT: begin
				state_d = srl_pkg::S_FINISH;
			end
			srl_pkg::S_FINISH: begin
				if (stat.out_free) begin
					state_d = srl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = srl_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		ctrl = '0;
		case (state_q)
			srl_pkg::S_IDLE: begin
				ctrl.ld_item = req_valid;
			end
			srl_pkg::S_EXEC: begin
				case (stat.cmd)
					srl_pkg::CMD_APPEND: begin
						if (stat.full) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = srl_pkg::ST_FULL;
						end else begin
							ctrl.mem_wr   = 1'b1;
							ctrl.wr_sel   = srl_pkg::WR_TAIL;
							ctrl.fill_inc = 1'b1;
						end
					end
					srl_pkg::CMD_INSERT: begin
						// bad position is checked ahead of full
						if (stat.pos_gt_fill) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = srl_pkg::ST_BADPOS;
						end else if (stat.full) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = srl_pkg::ST_FULL;
						end else begin
							ctrl.idx_load_fill = 1'b1;
						end
					end
					srl_pkg::CMD_FIND: begin
						ctrl.idx_clr = 1'b1;
					end
					srl_pkg::CMD_DELETE: begin
						if (stat.empty) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = srl_pkg::ST_EMPTY;
						end else begin
							ctrl.fill_dec = 1'b1;
						end
					end
					srl_pkg::CMD_READ: begin
						if (stat.empty) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = srl_pkg::ST_EMPTY;
						end else if (stat.pos_ge_fill) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = srl_pkg::ST_BADPOS;
						end else begin
							ctrl.mem_rd = 1'b1;
							ctrl.rd_sel = srl_pkg::RD_POS;
						end
					end
					srl_pkg::CMD_CLEAR: begin
						ctrl.fill_clr = 1'b1;
					end
					default: begin
					end
				endcase
			end
			srl_pkg::S_SHIFT_RD: begin
				if (stat.idx_gt_pos) begin
					ctrl.mem_rd = 1'b1;
					ctrl.rd_sel = srl_pkg::RD_IDX_PREV;
				end else begin
					ctrl.mem_wr   = 1'b1;
					ctrl.wr_sel   = srl_pkg::WR_POS;
					ctrl.fill_inc = 1'b1;
				end
			end
			srl_pkg::S_SHIFT_WR: begin
				ctrl.mem_wr  = 1'b1;
				ctrl.wr_sel  = srl_pkg::WR_IDX;
				ctrl.idx_dec = 1'b1;
			end
			srl_pkg::S_FIND_RD: begin
				if (stat.idx_lt_fill) begin
					ctrl.mem_rd = 1'b1;
					ctrl.rd_sel = srl_pkg::RD_IDX;
				end
			end
			srl_pkg::S_FIND_CMP: begin
				if (stat.match) begin
					ctrl.found_set = 1'b1;
				end else begin
					ctrl.idx_inc = 1'b1;
				end
			end
			srl_pkg::S_READ_WAIT: begin
				ctrl.rdout_cap = 1'b1;
			end
			srl_pkg::S_FINISH: begin
				ctrl.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/srl_dpath.sv */
// Datapath for the sequential record list: record memory, counters, result register.
`default_nettype none

module srl_dpath #(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire srl_pkg::req_t  req_data,
	input  wire srl_pkg::ctrl_t ctrl,
	output srl_pkg::stat_t      stat,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output srl_pkg::rsp_t       rsp_data
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > srl_pkg::POS_W) ? CW : srl_pkg::POS_W;

	srl_pkg::rec_t mem [CAPACITY];

	logic [2:0]              cmd_q;
	logic [srl_pkg::POS_W-1:0] pos_q;
	srl_pkg::rec_t           rec_q;
	srl_pkg::rec_t           rd_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           idx_q;
	srl_pkg::status_t        status_q;
	logic                    found_q;
	srl_pkg::rec_t           rdout_q;
	logic                    out_valid_q;
	srl_pkg::rsp_t           out_data_q;

	logic [PW-1:0] pos_ext, fill_ext, idx_ext;
	logic [AW-1:0] pos_addr, idx_addr, prev_addr, fill_addr;
	logic [AW-1:0] rd_addr, wr_addr;
	srl_pkg::rec_t wr_data;

	assign pos_ext   = PW'(pos_q);
	assign fill_ext  = PW'(fill_q);
	assign idx_ext   = PW'(idx_q);
	assign pos_addr  = AW'(pos_ext);
	assign idx_addr  = AW'(idx_q);
	assign prev_addr = AW'(idx_q - 1'b1);
	assign fill_addr = AW'(fill_q);

	always_comb begin
		case (ctrl.rd_sel)
			srl_pkg::RD_POS:      rd_addr = pos_addr;
			srl_pkg::RD_IDX:      rd_addr = idx_addr;
			srl_pkg::RD_IDX_PREV: rd_addr = prev_addr;
			default:              rd_addr = idx_addr;
		endcase
	end

	always_comb begin
		case (ctrl.wr_sel)
			srl_pkg::WR_TAIL: begin
				wr_addr = fill_addr;
				wr_data = rec_q;
			end
			srl_pkg::WR_POS: begin
				wr_addr = pos_addr;
				wr_data = rec_q;
			end
			srl_pkg::WR_IDX: begin
				// shift step: entry idx-1 read last cycle moves up to idx
				wr_addr = idx_addr;
				wr_data = rd_q;
			end
			default: begin
				wr_addr = idx_addr;
				wr_data = rd_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Item and result payload registers
	always_ff @(posedge clk) begin
		if (ctrl.ld_item) begin
			cmd_q    <= req_data.cmd;
			pos_q    <= req_data.position;
			rec_q    <= '{age: req_data.in_age, height: req_data.in_height,
				weight: req_data.in_weight};
			status_q <= srl_pkg::ST_OK;
			found_q  <= 1'b0;
			rdout_q  <= '0;
		end else begin
			if (ctrl.st_set) begin
				status_q <= ctrl.st_code;
			end
			if (ctrl.found_set) begin
				found_q <= 1'b1;
			end
			if (ctrl.rdout_cap) begin
				rdout_q <= rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.idx_load_fill) begin
			idx_q <= fill_q;
		end else if (ctrl.idx_clr) begin
			idx_q <= '0;
		end else if (ctrl.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end else if (ctrl.idx_dec) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.fill_clr) begin
			fill_q <= '0;
		end else if (ctrl.fill_inc) begin
			fill_q <= fill_q + 1'b1;
		end else if (ctrl.fill_dec) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_data_q <= '{status: status_q, found: found_q,
				out_age: rdout_q.age, out_height: rdout_q.height,
				out_weight: rdout_q.weight,
				entry_count: srl_pkg::COUNT_W'(fill_q)};
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_data_q;

	assign stat.cmd         = cmd_q;
	assign stat.full        = (fill_q == CW'(CAPACITY));
	assign stat.empty       = (fill_q == '0);
	assign stat.pos_gt_fill = (pos_ext > fill_ext);
	assign stat.pos_ge_fill = (pos_ext >= fill_ext);
	assign stat.idx_gt_pos  = (idx_ext > pos_ext);
	assign stat.idx_lt_fill = (idx_q < fill_q);
	assign stat.match       = (rd_q == rec_q);
	assign stat.out_free    = !out_valid_q || rsp_ready;

endmodule

`default_nettype wire
